// File: rtl/telnet_command_filter_naws_defines.svh
// Assertion macros for the telnet command filter checker.
`ifndef TELNET_COMMAND_FILTER_NAWS_DEFINES_SVH
`define TELNET_COMMAND_FILTER_NAWS_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define TNF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tnf check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define TNF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tnf check failed");

`endif

// File: rtl/tnf_pkg.sv
// Package for the telnet command filter: protocol bytes and parser modes.
package tnf_pkg;

   localparam logic [7:0] IAC             = 8'd255;
   localparam logic [7:0] DONT            = 8'd254;
   localparam logic [7:0] DO              = 8'd253;
   localparam logic [7:0] WONT            = 8'd252;
   localparam logic [7:0] WILL            = 8'd251;
   localparam logic [7:0] SB              = 8'd250;
   localparam logic [7:0] SE              = 8'd240;
   localparam logic [7:0] OPT_WINDOW_SIZE = 8'd31;

   typedef enum logic [2:0] {
      MODE_DATA  = 3'd0,
      MODE_IAC   = 3'd1,
      MODE_VERB  = 3'd2,
      MODE_SBOPT = 3'd3,
      MODE_SKIP  = 3'd4,
      MODE_NAWS  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      NAWS_WIDTH_HI  = 2'd0,
      NAWS_WIDTH_LO  = 2'd1,
      NAWS_HEIGHT_HI = 2'd2,
      NAWS_HEIGHT_LO = 2'd3
   } naws_step_type;

endpackage

// File: rtl/telnet_command_filter_naws.sv
// An accepted req beat is registered and shows as its rsp beat in the next cycle.
// One byte per cycle unless rsp stalls; parser state updates in the accepting cycle.
// req_ready stays high while the rsp register is empty or being taken.
// Synchronous active-high reset: data mode, no size seen, cols and rows zero.
// Telnet command filter with NAWS window-size capture.
module telnet_command_filter_naws (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_pass_data,
   output logic       rsp_size_update,
   output logic       rsp_has_size,
   output logic [15:0] rsp_cols,
   output logic [15:0] rsp_rows
);
   import tnf_pkg::*;

   mode_type      mode_ff, mode_in;
   naws_step_type step_ff, step_in;
   logic [15:0]   width_ff, width_in;
   logic [7:0]    height_hi_ff, height_hi_in;
   logic          seen_ff, seen_in;
   logic [15:0]   cols_ff, cols_in;
   logic [15:0]   rows_ff, rows_in;
   logic          valid_ff;
   logic          pass_ff, pass_in;
   logic          upd_ff, upd_in;
   logic          take;
   logic          is_verb;

   assign req_ready = !valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign is_verb   = (req_rx_byte == WILL) || (req_rx_byte == WONT) ||
                      (req_rx_byte == DO) || (req_rx_byte == DONT);

   always_comb begin
      mode_in      = mode_ff;
      step_in      = step_ff;
      width_in     = width_ff;
      height_hi_in = height_hi_ff;
      seen_in      = seen_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      pass_in      = 1'b0;
      upd_in       = 1'b0;
      case (mode_ff)
         MODE_IAC: begin
            if (is_verb) begin
               mode_in = MODE_VERB;
            end else if (req_rx_byte == SB) begin
               mode_in = MODE_SBOPT;
            end else if (req_rx_byte == IAC) begin
               // doubled IAC is a literal 255
               pass_in = 1'b1;
               mode_in = MODE_DATA;
            end else begin
               mode_in = MODE_DATA;
            end
         end
         MODE_VERB: begin
            mode_in = MODE_DATA;
         end
         MODE_SBOPT: begin
            step_in = NAWS_WIDTH_HI;
            if (req_rx_byte == OPT_WINDOW_SIZE) begin
               mode_in = MODE_NAWS;
            end else if (req_rx_byte == IAC) begin
               mode_in = MODE_IAC;
            end else begin
               mode_in = MODE_SKIP;
            end
         end
         MODE_SKIP: begin
            if (req_rx_byte == IAC) begin
               mode_in = MODE_IAC;
            end
         end
         MODE_NAWS: begin
            // every byte here is a size byte, 255 included
            case (step_ff)
               NAWS_WIDTH_HI: begin
                  width_in     = {8'd0, req_rx_byte};
                  height_hi_in = 8'd0;
                  step_in      = NAWS_WIDTH_LO;
               end
               NAWS_WIDTH_LO: begin
                  width_in = {width_ff[7:0], req_rx_byte};
                  step_in  = NAWS_HEIGHT_HI;
               end
               NAWS_HEIGHT_HI: begin
                  height_hi_in = req_rx_byte;
                  step_in      = NAWS_HEIGHT_LO;
               end
               default: begin
                  cols_in = width_ff;
                  rows_in = {height_hi_ff, req_rx_byte};
                  seen_in = 1'b1;
                  upd_in  = 1'b1;
                  step_in = NAWS_WIDTH_HI;
                  mode_in = MODE_DATA;
               end
            endcase
         end
         default: begin
            if (req_rx_byte == IAC) begin
               mode_in = MODE_IAC;
            end else begin
               pass_in = 1'b1;
               mode_in = MODE_DATA;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DATA;
         step_ff      <= NAWS_WIDTH_HI;
         width_ff     <= 16'd0;
         height_hi_ff <= 8'd0;
         seen_ff      <= 1'b0;
         cols_ff      <= 16'd0;
         rows_ff      <= 16'd0;
         valid_ff     <= 1'b0;
      end else begin
         if (take) begin
            mode_ff      <= mode_in;
            step_ff      <= step_in;
            width_ff     <= width_in;
            height_hi_ff <= height_hi_in;
            seen_ff      <= seen_in;
            cols_ff      <= cols_in;
            rows_ff      <= rows_in;
            valid_ff     <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         pass_ff <= pass_in;
         upd_ff  <= upd_in;
      end
   end

   // size state only moves with a new beat, so it doubles as the rsp payload
   assign rsp_valid       = valid_ff;
   assign rsp_pass_data   = pass_ff;
   assign rsp_size_update = upd_ff;
   assign rsp_has_size    = seen_ff;
   assign rsp_cols        = cols_ff;
   assign rsp_rows        = rows_ff;

endmodule

// File: rtl/tnf_checker.sv
// Port-level checker for the telnet command filter, bound to the top level.
`include "telnet_command_filter_naws_defines.svh"

module tnf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_pass_data,
   input logic        rsp_size_update,
   input logic        rsp_has_size,
   input logic [15:0] rsp_cols,
   input logic [15:0] rsp_rows
);

   // a completed size report implies the sticky flag and is never data
   `TNF_ASSERT_NOW(a_upd_sets_flag, rsp_valid && rsp_size_update, rsp_has_size)
   `TNF_ASSERT_NOW(a_upd_not_data, rsp_valid && rsp_size_update, !rsp_pass_data)
   `TNF_ASSERT_NEXT(a_flag_sticky, rsp_has_size, rsp_has_size)
   // window size only changes with the beat that reports it
   `TNF_ASSERT_NOW(a_size_moves_on_upd,
                   !$stable(rsp_cols) || !$stable(rsp_rows),
                   rsp_valid && rsp_size_update)
   `TNF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_pass_data) && $stable(rsp_size_update))

endmodule

bind telnet_command_filter_naws tnf_checker u_tnf_checker (.*);

// File: tb/tb_telnet_command_filter_naws.sv
// Self-checking testbench for the telnet command filter with NAWS capture.
`timescale 1ns / 100ps

module tb_telnet_command_filter_naws;
   import tnf_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int STALL_LIMIT  = 500;
   localparam int RANDOM_BYTES = 450;
   localparam int CALM_TAIL    = 60;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic        pass_data;
      logic        size_update;
      logic        has_size;
      logic [15:0] cols;
      logic [15:0] rows;
   } byte_verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_pass_data;
   logic        rsp_size_update;
   logic        rsp_has_size;
   logic [15:0] rsp_cols;
   logic [15:0] rsp_rows;

   logic [7:0]       rx_stream[$];
   byte_verdict_type byte_verdicts[$];
   int               stream_len = 0;
   int               beats_out = 0;
   int               gap_left = 0;
   int               stall_left = 0;
   int               quiet_cycles = 0;
   int               mismatches = 0;

   // predictor state
   mode_type      parser_mode = MODE_DATA;
   naws_step_type naws_step = NAWS_WIDTH_HI;
   logic [15:0]   width_acc = 16'h0000;
   logic [15:0]   height_acc = 16'h0000;
   logic          size_seen = 1'b0;
   logic [15:0]   cols_latched = 16'h0000;
   logic [15:0]   rows_latched = 16'h0000;

   telnet_command_filter_naws dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pass_data   (rsp_pass_data),
      .rsp_size_update (rsp_size_update),
      .rsp_has_size    (rsp_has_size),
      .rsp_cols        (rsp_cols),
      .rsp_rows        (rsp_rows)
   );

   always #1 clock = ~clock;

   task automatic log_mismatch(input string msg);
      $display("ERROR beat %0d: %s", beats_out, msg);
      mismatches++;
   endtask

   // idling is off in every third window of 40 beats and in the tail
   function automatic bit idling_on(input int done);
      return (done < stream_len - CALM_TAIL) && ((done / 40) % 3 != 2);
   endfunction

   function automatic logic [7:0] plain_byte();
      return 8'($urandom_range(0, 254));
   endfunction

   function automatic logic [7:0] size_byte();
      case ($urandom_range(0, 5))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic byte_verdict_type parse_byte(input logic [7:0] b);
      byte_verdict_type v;
      v = '0;
      case (parser_mode)
         MODE_IAC: begin
            if (b == WILL || b == WONT || b == DO || b == DONT) parser_mode = MODE_VERB;
            else if (b == SB) parser_mode = MODE_SBOPT;
            else if (b == IAC) begin
               v.pass_data = 1'b1;
               parser_mode = MODE_DATA;
            end else parser_mode = MODE_DATA;
         end
         MODE_VERB: parser_mode = MODE_DATA;
         MODE_SBOPT: begin
            naws_step = NAWS_WIDTH_HI;
            if (b == OPT_WINDOW_SIZE) parser_mode = MODE_NAWS;
            else if (b == IAC) parser_mode = MODE_IAC;
            else parser_mode = MODE_SKIP;
         end
         MODE_SKIP: begin
            if (b == IAC) parser_mode = MODE_IAC;
         end
         MODE_NAWS: begin
            // every byte here is size data, 255 included
            case (naws_step)
               NAWS_WIDTH_HI: begin
                  width_acc = {8'h00, b};
                  height_acc = 16'h0000;
                  naws_step = NAWS_WIDTH_LO;
               end
               NAWS_WIDTH_LO: begin
                  width_acc = {width_acc[7:0], b};
                  naws_step = NAWS_HEIGHT_HI;
               end
               NAWS_HEIGHT_HI: begin
                  height_acc = {8'h00, b};
                  naws_step = NAWS_HEIGHT_LO;
               end
               default: begin
                  height_acc = {height_acc[7:0], b};
                  naws_step = NAWS_WIDTH_HI;
                  cols_latched = width_acc;
                  rows_latched = height_acc;
                  size_seen = 1'b1;
                  v.size_update = 1'b1;
                  parser_mode = MODE_DATA;
               end
            endcase
         end
         default: begin
            if (b == IAC) parser_mode = MODE_IAC;
            else begin
               parser_mode = MODE_DATA;
               v.pass_data = 1'b1;
            end
         end
      endcase
      v.has_size = size_seen;
      v.cols = cols_latched;
      v.rows = rows_latched;
      return v;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_rx_byte <= 8'h00;
         gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (rx_stream.size() != 0
                      && idling_on(stream_len - rx_stream.size())
                      && $urandom_range(0, 4) == 0) begin
            gap_left = $urandom_range(0, 4);
            req_valid <= 1'b0;
         end else if (rx_stream.size() != 0) begin
            req_valid <= 1'b1;
            req_rx_byte <= rx_stream.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: predicts on each req beat, checks each rsp beat
   always @(posedge clock) begin
      byte_verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (req_valid && req_ready) byte_verdicts.push_back(parse_byte(req_rx_byte));
         if (rsp_valid && rsp_ready) begin
            if (byte_verdicts.size() == 0) begin
               log_mismatch("rsp beat with nothing expected");
            end else begin
               want = byte_verdicts.pop_front();
               if (rsp_pass_data !== want.pass_data)
                  log_mismatch($sformatf("pass_data got %b want %b",
                                         rsp_pass_data, want.pass_data));
               if (rsp_size_update !== want.size_update)
                  log_mismatch($sformatf("size_update got %b want %b",
                                         rsp_size_update, want.size_update));
               if (rsp_has_size !== want.has_size)
                  log_mismatch($sformatf("has_size got %b want %b",
                                         rsp_has_size, want.has_size));
               if (rsp_cols !== want.cols)
                  log_mismatch($sformatf("cols got %h want %h", rsp_cols, want.cols));
               if (rsp_rows !== want.rows)
                  log_mismatch($sformatf("rows got %h want %h", rsp_rows, want.rows));
            end
            beats_out++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idling_on(beats_out) && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles", STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int kind;
      int n;
      logic [7:0] opt;
      // directed: data extremes, doubled IAC, verb, SE and stray byte after IAC,
      // NAWS of all 255s, IAC as SB option, foreign subneg, verb with option 255
      rx_stream = '{8'h00, IAC, IAC, IAC, WILL, 8'h01, IAC, SE, IAC, 8'h80,
                    IAC, SB, OPT_WINDOW_SIZE, 8'hff, 8'hff, 8'hff, 8'hff,
                    IAC, SB, IAC, SE, IAC, SB, 8'd24, IAC, SE, IAC, DONT, IAC};
      n = rx_stream.size();
      while (rx_stream.size() < n + RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            rx_stream.push_back(plain_byte());
         end else if (kind < 33) begin
            rx_stream.push_back(IAC);
            rx_stream.push_back(IAC);
         end else if (kind < 50) begin
            rx_stream.push_back(IAC);
            case ($urandom_range(0, 3))
               0:       rx_stream.push_back(WILL);
               1:       rx_stream.push_back(WONT);
               2:       rx_stream.push_back(DO);
               default: rx_stream.push_back(DONT);
            endcase
            rx_stream.push_back(8'($urandom_range(0, 255)));
         end else if (kind < 70) begin
            rx_stream.push_back(IAC);
            rx_stream.push_back(SB);
            rx_stream.push_back(OPT_WINDOW_SIZE);
            repeat (4) rx_stream.push_back(size_byte());
            if ($urandom_range(0, 1) == 0) begin
               rx_stream.push_back(IAC);
               rx_stream.push_back(SE);
            end
         end else if (kind < 82) begin
            do opt = plain_byte(); while (opt == OPT_WINDOW_SIZE);
            rx_stream.push_back(IAC);
            rx_stream.push_back(SB);
            rx_stream.push_back(opt);
            repeat ($urandom_range(0, 4)) rx_stream.push_back(plain_byte());
            rx_stream.push_back(IAC);
            rx_stream.push_back(SE);
         end else if (kind < 90) begin
            rx_stream.push_back(IAC);
            rx_stream.push_back(8'($urandom_range(0, 255)));
         end else begin
            rx_stream.push_back(8'($urandom_range(0, 255)));
         end
      end
      stream_len = rx_stream.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (rx_stream.size() != 0 || req_valid || byte_verdicts.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
